>>> rtl/tbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants of the tournament branch predictor
// Counter encodings, reset values, result word layout and the bimodal
// state transition function.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // result queue
  localparam int QDEPTH = 16;
  localparam int QAW    = 4;

  // table reset values
  localparam logic [1:0] GSH_RESET = 2'd0;
  localparam logic [2:0] BIM_RESET = 3'd6;
  localparam logic [1:0] CHO_RESET = 2'd3;

  // prediction thresholds
  localparam logic [2:0] BIM_TAKEN_MAX = 3'd3;  // bimodal predicts taken at or below
  localparam logic [1:0] GSH_TAKEN_MIN = 2'd2;  // gshare predicts taken at or above
  localparam logic [1:0] CHO_GSH_MAX   = 2'd1;  // chooser selects gshare at or below
  localparam logic [1:0] CNT2_MAX      = 2'd3;
  localparam logic [1:0] CNT2_MIN      = 2'd0;

  // control sequencer
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } st_t;

  // bimodal + chooser share one table entry
  typedef struct packed {
    logic [2:0] bim;
    logic [1:0] cho;
  } bc_t;

  // result word, predicted_taken in bit 0
  typedef struct packed {
    logic [31:0] correct_total;
    logic        used_gshare;
    logic        prediction_correct;
    logic        predicted_taken;
  } res_t;

  // six-state bimodal transitions; codes 0 and 7 hold
  function automatic logic [2:0] bimodal_next(input logic [2:0] s, input logic taken);
    logic [2:0] n;
    n = s;
    if (taken) begin
      case (s)
        3'd2:    n = 3'd1;
        3'd3:    n = 3'd2;
        3'd4:    n = 3'd3;
        3'd5:    n = 3'd4;
        3'd6:    n = 3'd5;
        default: n = s;
      endcase
    end else begin
      case (s)
        3'd1:    n = 3'd2;
        3'd2:    n = 3'd4;
        3'd3:    n = 3'd4;
        3'd4:    n = 3'd5;
        3'd5:    n = 3'd6;
        default: n = s;
      endcase
    end
    return n;
  endfunction

endpackage

>>> rtl/tbp_modn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_modn: pipelined remainder by a constant
// Three stages: reciprocal multiply, quotient times divisor, subtract with
// one correction step. Carries a sideband word along; never stalls.
// ----------------------------------------------------------------------------
module tbp_modn #(
  parameter int XW = 32,
  parameter int N  = 4096,
  parameter int SW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [XW-1:0]         in_x,
  input  logic [SW-1:0]         in_side,
  output logic                  out_vld,
  output logic [$clog2(N)-1:0]  out_r,
  output logic [SW-1:0]         out_side
);

  localparam int RW = $clog2(N);
  localparam int MW = XW - RW + 1;
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / N);
  localparam logic [XW:0]   NX    = (XW + 1)'(N);

  logic                 v1_r, v2_r, v3_r;
  logic [XW-1:0]        x1_r, x2_r;
  logic [XW+MW-1:0]     prod1_r;
  logic [XW-1:0]        qn2_r;
  logic [SW-1:0]        s1_r, s2_r, s3_r;
  logic [RW-1:0]        r3_r;
  logic [MW-1:0]        q_est;
  logic [XW:0]          diff;
  logic [RW-1:0]        r_nxt;

  // estimated quotient is the true one or one less
  assign q_est = prod1_r[XW+MW-1:XW];

  // remainder estimate stays below twice the divisor
  always_comb begin
    diff = {1'b0, x2_r - qn2_r};
    if (diff >= NX) begin
      r_nxt = RW'(diff - NX);
    end else begin
      r_nxt = RW'(diff);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload stages; quotient times divisor never exceeds the dividend
  always_ff @(posedge clk) begin
    x1_r    <= in_x;
    prod1_r <= in_x * RECIP;
    s1_r    <= in_side;
    x2_r    <= x1_r;
    qn2_r   <= XW'((XW + 1)'(q_est) * NX);
    s2_r    <= s1_r;
    r3_r    <= r_nxt;
    s3_r    <= s2_r;
  end

  assign out_vld  = v3_r;
  assign out_r    = r3_r;
  assign out_side = s3_r;

endmodule

>>> rtl/tbp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram: simple dual-port synchronous RAM
// One write port, one read port with registered data (read-before-write).
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int W     = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tbp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_fifo: result queue
// Holds finished result words until the receiver takes them. The caller
// keeps it from overflowing by credit.
// ----------------------------------------------------------------------------
module tbp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tbp_pkg::res_t push_data,
  input  logic          pop,
  output logic          vld,
  output tbp_pkg::res_t data
);

  tbp_pkg::res_t          mem_r [tbp_pkg::QDEPTH];
  logic [tbp_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [tbp_pkg::QAW:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign vld  = (cnt_r != '0);
  assign data = mem_r[rd_ptr_r];

endmodule

>>> rtl/tournament_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit: gshare / bimodal tournament predictor
// Takes one resolved branch per word and returns one prediction word.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one resolved branch per word (pc and actual outcome).
//   out_* : one result per input word, in order: final prediction, whether it
//           was correct, whether gshare was chosen, running correct count.
//   Throughput is one word per cycle while in_tready is high; tables are
//   updated read-modify-write with forwarding from the write port, so
//   back-to-back branches to the same entry see each other's updates.
//   Path: an accepted input word passes two 3-stage index reduction pipelines
//   and one RAM read; the update stage writes the result queue directly, and
//   out_tvalid rises once the queue holds the result.
//   Reset: after rst_n is released the three tables are cleared one entry per
//   cycle, all TABLE_ENTRIES entries, with in_tready low during that pass.
//   Stall: results collect in a 16-word queue; in_tready drops once 16 words
//   are accepted but not yet taken, so nothing is lost while out_tready is low.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int HISTORY_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] branch_pc, [32] branch_taken
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbp_pkg::OUT_TDATA_W-1:0]  out_tdata   // [0] predicted_taken,
                                                       // [1] prediction_correct,
                                                       // [2] used_gshare, [34:3] correct_total
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int HB  = HISTORY_BITS;
  localparam int XW2 = (HB > IW) ? HB : IW;
  localparam int RES_W = $bits(tbp_pkg::res_t);

  // control
  tbp_pkg::st_t            st_r, st_nxt;
  logic [IW-1:0]           clr_idx_r, clr_idx_nxt;
  logic [tbp_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic [HB-1:0]           hist_r, hist_nxt;
  logic                    in_acc, out_acc;

  // index pipelines
  logic                    m1_vld;
  logic [IW-1:0]           m1_bidx;
  logic [HB:0]             m1_side;
  logic [XW2-1:0]          m2_x;
  logic                    m2_vld;
  logic [IW-1:0]           m2_gidx;
  logic [IW:0]             m2_side;

  // update stage
  logic                    ex_vld_r, ex_taken_r;
  logic [IW-1:0]           ex_bidx_r, ex_gidx_r;
  logic [1:0]              g_rdata, g_cur, g_new;
  tbp_pkg::bc_t            bc_rdata, bc_cur, bc_new;
  logic                    bpred, gpred, use_g, fpred, hit;
  logic [31:0]             hit_count_r, hit_count_nxt;
  tbp_pkg::res_t           res;

  // table write port and forwarding copy
  logic                    wr_en;
  logic [IW-1:0]           wr_gaddr, wr_baddr;
  logic [1:0]              wr_gdata;
  tbp_pkg::bc_t            wr_bdata;
  logic                    fw_we_r;
  logic [IW-1:0]           fw_gaddr_r, fw_baddr_r;
  logic [1:0]              fw_gdata_r;
  tbp_pkg::bc_t            fw_bdata_r;

  // result queue
  logic                    q_vld;
  tbp_pkg::res_t           q_data;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // clear sequencer and credit count
  always_comb begin
    st_nxt      = st_r;
    clr_idx_nxt = clr_idx_r;
    in_tready   = 1'b0;
    case (st_r)
      tbp_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IW'(TABLE_ENTRIES - 1)) begin
          st_nxt = tbp_pkg::ST_RUN;
        end
      end
      tbp_pkg::ST_RUN: begin
        in_tready = (cnt_r < (tbp_pkg::QAW + 1)'(tbp_pkg::QDEPTH));
      end
      default: begin
        st_nxt = tbp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // history shifts at acceptance; the item carries the value before its own bit
  assign hist_nxt = in_acc ? HB'({hist_r, in_tdata[32]}) : hist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tbp_pkg::ST_CLEAR;
      clr_idx_r <= '0;
      cnt_r     <= '0;
      hist_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      clr_idx_r <= clr_idx_nxt;
      cnt_r     <= cnt_nxt;
      hist_r    <= hist_nxt;
    end
  end

  // bimodal index: pc mod TABLE_ENTRIES
  tbp_modn #(
    .XW (32),
    .N  (TABLE_ENTRIES),
    .SW (HB + 1)
  ) u_mod_pc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_acc),
    .in_x     (in_tdata[31:0]),
    .in_side  ({in_tdata[32], hist_r}),
    .out_vld  (m1_vld),
    .out_r    (m1_bidx),
    .out_side (m1_side)
  );

  // gshare index: (bimodal index ^ history) mod TABLE_ENTRIES
  assign m2_x = XW2'(m1_bidx) ^ XW2'(m1_side[HB-1:0]);

  tbp_modn #(
    .XW (XW2),
    .N  (TABLE_ENTRIES),
    .SW (IW + 1)
  ) u_mod_gs (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (m1_vld),
    .in_x     (m2_x),
    .in_side  ({m1_side[HB], m1_bidx}),
    .out_vld  (m2_vld),
    .out_r    (m2_gidx),
    .out_side (m2_side)
  );

  // tables
  tbp_ram #(
    .W     (2),
    .DEPTH (TABLE_ENTRIES)
  ) u_gsh_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_gaddr),
    .wdata (wr_gdata),
    .raddr (m2_gidx),
    .rdata (g_rdata)
  );

  tbp_ram #(
    .W     ($bits(tbp_pkg::bc_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_bc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_baddr),
    .wdata (wr_bdata),
    .raddr (m2_side[IW-1:0]),
    .rdata (bc_rdata)
  );

  // update stage registers, aligned with the RAM read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r <= 1'b0;
      fw_we_r  <= 1'b0;
    end else begin
      ex_vld_r <= m2_vld;
      fw_we_r  <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    ex_taken_r <= m2_side[IW];
    ex_bidx_r  <= m2_side[IW-1:0];
    ex_gidx_r  <= m2_gidx;
    fw_gaddr_r <= wr_gaddr;
    fw_baddr_r <= wr_baddr;
    fw_gdata_r <= wr_gdata;
    fw_bdata_r <= wr_bdata;
  end

  // forward the write made while this entry was being read
  assign g_cur  = (fw_we_r && fw_gaddr_r == ex_gidx_r) ? fw_gdata_r : g_rdata;
  assign bc_cur = (fw_we_r && fw_baddr_r == ex_bidx_r) ? fw_bdata_r : bc_rdata;

  // predictions
  assign bpred = (bc_cur.bim <= tbp_pkg::BIM_TAKEN_MAX);
  assign gpred = (g_cur >= tbp_pkg::GSH_TAKEN_MIN);
  assign use_g = (bc_cur.cho <= tbp_pkg::CHO_GSH_MAX);
  assign fpred = use_g ? gpred : bpred;
  assign hit   = (fpred == ex_taken_r);

  // counter training
  always_comb begin
    bc_new.cho = bc_cur.cho;
    if (gpred != bpred) begin
      if (gpred == ex_taken_r) begin
        if (bc_cur.cho != tbp_pkg::CNT2_MIN) begin
          bc_new.cho = bc_cur.cho - 1'b1;
        end
      end else begin
        if (bc_cur.cho != tbp_pkg::CNT2_MAX) begin
          bc_new.cho = bc_cur.cho + 1'b1;
        end
      end
    end
    bc_new.bim = tbp_pkg::bimodal_next(bc_cur.bim, ex_taken_r);
    g_new = g_cur;
    if (ex_taken_r) begin
      if (g_cur != tbp_pkg::CNT2_MAX) begin
        g_new = g_cur + 1'b1;
      end
    end else begin
      if (g_cur != tbp_pkg::CNT2_MIN) begin
        g_new = g_cur - 1'b1;
      end
    end
  end

  // write port: clear pass or update
  always_comb begin
    if (st_r == tbp_pkg::ST_CLEAR) begin
      wr_en        = 1'b1;
      wr_gaddr     = clr_idx_r;
      wr_baddr     = clr_idx_r;
      wr_gdata     = tbp_pkg::GSH_RESET;
      wr_bdata.bim = tbp_pkg::BIM_RESET;
      wr_bdata.cho = tbp_pkg::CHO_RESET;
    end else begin
      wr_en    = ex_vld_r;
      wr_gaddr = ex_gidx_r;
      wr_baddr = ex_bidx_r;
      wr_gdata = g_new;
      wr_bdata = bc_new;
    end
  end

  // saturating hit counter
  assign hit_count_nxt = (ex_vld_r && hit && hit_count_r != 32'hFFFF_FFFF) ?
                         hit_count_r + 32'd1 : hit_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_count_r <= '0;
    end else begin
      hit_count_r <= hit_count_nxt;
    end
  end

  assign res.correct_total      = hit_count_nxt;
  assign res.used_gshare        = use_g;
  assign res.prediction_correct = hit;
  assign res.predicted_taken    = fpred;

  tbp_fifo u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ex_vld_r),
    .push_data (res),
    .pop       (out_acc),
    .vld       (q_vld),
    .data      (q_data)
  );

  assign out_tvalid = q_vld;
  assign out_tdata  = {(tbp_pkg::OUT_TDATA_W - RES_W)'(0), q_data};

  // no table update may overlap the clear pass
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ex_vld_r |-> st_r == tbp_pkg::ST_RUN)
    else $error("table update during clear pass");

  // a queued result is always covered by the credit count
  a_credit_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result present without outstanding credit");

  // correct count never goes backward
  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_count_r >= $past(hit_count_r))
    else $error("correct count decreased");

endmodule
